/* rtl/radial_light_map_accumulator_top_assert.svh */
// Assertion macros for the radial light map accumulator.
// Taken in by radial_light_map_accumulator_top; expects clk and rst_n in scope.
`ifndef RADIAL_LIGHT_MAP_ACCUMULATOR_TOP_ASSERT_SVH
`define RADIAL_LIGHT_MAP_ACCUMULATOR_TOP_ASSERT_SVH

// same-cycle implication
`define RLMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rlma_pkg.sv */
// Shared types and constants for the radial light map accumulator.
// No dependencies; used by rlma_alu, radial_light_map_accumulator_top, rlma_light_map_checker and tb.
package rlma_pkg;

  // request kinds (tuser bit on the input side)
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [7:0] LEVEL_MAX = 8'd255;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  // in_tdata field positions
  localparam int TY_LSB = 0;
  localparam int TX_LSB = 4;
  localparam int RT_LSB = 8;
  localparam int PY_LSB = 12;
  localparam int PX_LSB = 20;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP
  } rlma_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_DATA,
    ST_SETUP,
    ST_WIN,
    ST_DY,
    ST_DX,
    ST_DIV,
    ST_RECIP,
    ST_P_RD,
    ST_P_MIX,
    ST_P_SCALE,
    ST_P_CORR,
    ST_P_WR,
    ST_RESP
  } rlma_state_t;

endpackage

/* rtl/rlma_alu.sv */
// Shared arithmetic unit: registered multiplier and restoring divide step.
// Depends on rlma_pkg for the operation codes.
module rlma_alu
  import rlma_pkg::*;
#(
  parameter int AW = 24
) (
  input  logic              clk,
  input  rlma_op_t          op,
  input  logic [AW-1:0]     a,
  input  logic [AW-1:0]     b,
  output logic [2*AW-1:0]   res
);

  logic [2*AW-1:0] prod_r, prod_nxt;
  logic [AW:0]     rem_r, rem_nxt;
  logic [AW-1:0]   dvs_r, dvs_nxt;
  logic [AW:0]     rem_dbl;
  logic            rem_ge;

  assign rem_dbl = {rem_r[AW-1:0], 1'b0};
  assign rem_ge  = rem_dbl >= {1'b0, dvs_r};

  always_comb begin
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    case (op)
      OP_MUL: begin
        prod_nxt = a * b;
      end
      OP_DIV_INIT: begin
        // dividend is a single one followed by zeros
        rem_nxt  = (AW+1)'(1);
        dvs_nxt  = b;
        prod_nxt = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt  = rem_ge ? (rem_dbl - {1'b0, dvs_r}) : rem_dbl;
        prod_nxt = {{AW{1'b0}}, prod_r[AW-2:0], rem_ge};
      end
      default: begin
        prod_nxt = prod_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign res = prod_r;

endmodule

/* rtl/radial_light_map_accumulator_top.sv */
// Radial light map accumulator, top level: sequencer, light map memory, result register.
// Depends on rlma_pkg, rlma_alu and radial_light_map_accumulator_top_assert.svh.
//
//  channel | dir | tdata                         | tuser
//  in_     | in  | tile_y, tile_x, radius, py, px | req_type
//  out_    | out | light_level                   | was_add
//
// Reset clears the map, sweeping all 2**(YW+XW) addresses (65536 by default); no requests then.
// Read: ST_RD_REQ, ST_RD_DATA and ST_RESP lead to the result register. Add: set-up with an NW-step
// reciprocal in the shared unit, then per pixel of the clamped window a read and a mix, and for a lit
// one also scale, correct and write, the shared multiplier being used three times per lit pixel.
// One request at a time; a waiting result stalls only the request that finishes behind it.
module radial_light_map_accumulator_top
  import rlma_pkg::*;
#(
  parameter int TILE_PIXELS      = 16,
  parameter int MAP_HEIGHT_TILES = 16,
  parameter int MAP_WIDTH_TILES  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] source_tile_y, [7:4] source_tile_x, [11:8] radius_tiles,
  // [19:12] pixel_y, [27:20] pixel_x, [31:28] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] req_type
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] light_level
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] was_add
  output logic [0:0]             out_tuser
);

  `include "radial_light_map_accumulator_top_assert.svh"

  localparam int ROWS  = MAP_HEIGHT_TILES * TILE_PIXELS;
  localparam int COLS  = MAP_WIDTH_TILES * TILE_PIXELS;
  localparam int YW    = $clog2(ROWS);
  localparam int XW    = $clog2(COLS);
  localparam int MAW   = YW + XW;
  localparam int DEPTH = 1 << MAW;
  localparam int RW    = $clog2(15 * TILE_PIXELS + 1);
  localparam int R2W   = 2 * RW;
  localparam int NW    = R2W + 8;
  localparam int SW    = $clog2(128 * TILE_PIXELS) + 1;
  localparam int DW    = R2W + 2;
  localparam int CW    = $clog2(NW);

  localparam logic signed [SW-1:0] ROWS_S = SW'(ROWS);
  localparam logic signed [SW-1:0] COLS_S = SW'(COLS);

  function automatic logic signed [SW-1:0] clamp_hi(input logic signed [SW-1:0] v,
                                                     input logic signed [SW-1:0] hi);
    if (v < 0) return '0;
    else if (v > hi) return hi;
    else return v;
  endfunction

  function automatic logic [SW-1:0] abs_diff(input logic signed [SW-1:0] p,
                                             input logic signed [SW-1:0] q);
    logic signed [SW-1:0] d;
    d = p - q;
    return (d < 0) ? -d : d;
  endfunction

  // (d+1)^2 from d^2
  function automatic logic [R2W-1:0] sq_step(input logic [R2W-1:0] sq,
                                             input logic signed [SW-1:0] d);
    logic signed [DW-1:0] t;
    t = $signed({2'b00, sq}) + (DW'(d) <<< 1) + DW'(1);
    return t[R2W-1:0];
  endfunction

  // input fields
  logic [3:0] in_ty, in_tx, in_rt;
  logic [7:0] in_py, in_px;
  logic       in_req;

  assign in_ty  = in_tdata[TY_LSB +: 4];
  assign in_tx  = in_tdata[TX_LSB +: 4];
  assign in_rt  = in_tdata[RT_LSB +: 4];
  assign in_py  = in_tdata[PY_LSB +: 8];
  assign in_px  = in_tdata[PX_LSB +: 8];
  assign in_req = in_tuser[0];

  rlma_state_t state_r, state_nxt;

  logic                 kind_r, kind_nxt;
  logic                 in_map_r, in_map_nxt;
  logic signed [SW-1:0] cy_r, cy_nxt, cx_r, cx_nxt;
  logic [RW-1:0]        r_r, r_nxt;
  logic signed [SW-1:0] y0_r, y0_nxt, y1_r, y1_nxt, x0_r, x0_nxt, x1_r, x1_nxt;
  logic signed [SW-1:0] y_r, y_nxt, x_r, x_nxt;
  logic [R2W-1:0]       r2_r, r2_nxt;
  logic [R2W-1:0]       dysq_r, dysq_nxt, dxsq_r, dxsq_nxt, dx0sq_r, dx0sq_nxt;
  logic [NW-1:0]        recip_r, recip_nxt;
  logic [R2W:0]         len_r, len_nxt;
  logic [7:0]           m_r, m_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [7:0]           qe_r, qe_nxt;
  logic [CW-1:0]        div_cnt_r, div_cnt_nxt;
  logic [MAW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [7:0]           out_level_r, out_level_nxt;
  logic                 out_add_r, out_add_nxt;

  // light map
  logic [7:0]     light_map_r [DEPTH];
  logic [7:0]     rdata_r;
  logic           mem_we;
  logic [MAW-1:0] mem_waddr;
  logic [MAW-1:0] mem_raddr;
  logic [7:0]     mem_wdata;

  // shared unit
  rlma_op_t        alu_op;
  logic [NW-1:0]   alu_a, alu_b;
  logic [2*NW-1:0] alu_res;

  rlma_alu #(
    .AW (NW)
  ) u_alu (
    .clk (clk),
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  logic signed [SW-1:0] r_s;
  logic signed [SW-1:0] x_inc, y_inc;
  logic                 x_last, y_last, walk_done, win_empty, unlit, out_free;
  logic [NW-1:0]        rem_w;
  logic [NW-1:0]        r2_dbl;
  logic                 bump;
  logic                 in_win;
  rlma_state_t          adv_state;

  assign r_s       = $signed(SW'(r_r));
  assign x_inc     = x_r + SW'(1);
  assign y_inc     = y_r + SW'(1);
  assign x_last    = x_inc >= x1_r;
  assign y_last    = y_inc >= y1_r;
  assign walk_done = x_last && y_last;
  assign adv_state = walk_done ? ST_RESP : ST_P_RD;
  assign win_empty = (y0_r >= y1_r) || (x0_r >= x1_r);
  assign unlit     = len_r > {1'b0, r2_r};
  assign out_free  = !out_tvalid_r || out_tready;
  assign rem_w     = n_r - alu_res[NW-1:0];
  assign r2_dbl    = NW'({r2_r, 1'b0});
  assign bump      = rem_w >= NW'(r2_r);
  assign mem_raddr = {y_r[YW-1:0], x_r[XW-1:0]};
  assign in_win    = (y_r >= y0_r) && (y_r < y1_r) && (x_r >= x0_r) && (x_r < x1_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_tvalid) state_nxt = (in_req == REQ_READ) ? ST_RD_REQ : ST_SETUP;
      ST_RD_REQ:  state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_RESP;
      ST_SETUP:   state_nxt = (r_r == '0) ? ST_RESP : ST_WIN;
      ST_WIN:     state_nxt = win_empty ? ST_RESP : ST_DY;
      ST_DY:      state_nxt = ST_DX;
      ST_DX:      state_nxt = ST_DIV;
      ST_DIV:     if (div_cnt_r == CW'(NW - 1)) state_nxt = ST_RECIP;
      ST_RECIP:   state_nxt = ST_P_RD;
      ST_P_RD:    state_nxt = ST_P_MIX;
      ST_P_MIX:   state_nxt = unlit ? adv_state : ST_P_SCALE;
      ST_P_SCALE: state_nxt = ST_P_CORR;
      ST_P_CORR:  state_nxt = ST_P_WR;
      ST_P_WR:    state_nxt = adv_state;
      ST_RESP:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_nxt       = kind_r;
    in_map_nxt     = in_map_r;
    cy_nxt         = cy_r;
    cx_nxt         = cx_r;
    r_nxt          = r_r;
    y0_nxt         = y0_r;
    y1_nxt         = y1_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    y_nxt          = y_r;
    x_nxt          = x_r;
    r2_nxt         = r2_r;
    dysq_nxt       = dysq_r;
    dxsq_nxt       = dxsq_r;
    dx0sq_nxt      = dx0sq_r;
    recip_nxt      = recip_r;
    len_nxt        = len_r;
    m_nxt          = m_r;
    n_nxt          = n_r;
    qe_nxt         = qe_r;
    div_cnt_nxt    = div_cnt_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_level_nxt  = out_level_r;
    out_add_nxt    = out_add_r;
    alu_op         = OP_HOLD;
    alu_a          = '0;
    alu_b          = '0;
    mem_we         = 1'b0;
    mem_waddr      = {y_r[YW-1:0], x_r[XW-1:0]};
    mem_wdata      = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + MAW'(1);
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = in_req;
          cy_nxt     = SW'(in_ty) * SW'(TILE_PIXELS) + SW'(TILE_PIXELS / 2);
          cx_nxt     = SW'(in_tx) * SW'(TILE_PIXELS) + SW'(TILE_PIXELS / 2);
          r_nxt      = RW'(in_rt) * RW'(TILE_PIXELS);
          y_nxt      = SW'(in_py);
          x_nxt      = SW'(in_px);
          in_map_nxt = (int'(in_py) < ROWS) && (int'(in_px) < COLS);
        end
      end
      ST_RD_DATA: begin
        m_nxt = in_map_r ? rdata_r : 8'd0;
      end
      ST_SETUP: begin
        y0_nxt = clamp_hi(cy_r - r_s, ROWS_S);
        y1_nxt = clamp_hi(cy_r + r_s, ROWS_S);
        x0_nxt = clamp_hi(cx_r - r_s, COLS_S);
        x1_nxt = clamp_hi(cx_r + r_s, COLS_S);
        alu_op = OP_MUL;
        alu_a  = NW'(r_r);
        alu_b  = NW'(r_r);
      end
      ST_WIN: begin
        r2_nxt = alu_res[R2W-1:0];
        y_nxt  = y0_r;
        x_nxt  = x0_r;
        alu_op = OP_MUL;
        alu_a  = NW'(abs_diff(y0_r, cy_r));
        alu_b  = NW'(abs_diff(y0_r, cy_r));
      end
      ST_DY: begin
        dysq_nxt = alu_res[R2W-1:0];
        alu_op   = OP_MUL;
        alu_a    = NW'(abs_diff(x0_r, cx_r));
        alu_b    = NW'(abs_diff(x0_r, cx_r));
      end
      ST_DX: begin
        dx0sq_nxt   = alu_res[R2W-1:0];
        dxsq_nxt    = alu_res[R2W-1:0];
        div_cnt_nxt = '0;
        alu_op      = OP_DIV_INIT;
        alu_b       = NW'(r2_r);
      end
      ST_DIV: begin
        div_cnt_nxt = div_cnt_r + CW'(1);
        alu_op      = OP_DIV_STEP;
      end
      ST_RECIP: begin
        recip_nxt = alu_res[NW-1:0];
      end
      ST_P_RD: begin
        len_nxt = {1'b0, dxsq_r} + {1'b0, dysq_r};
      end
      ST_P_MIX: begin
        m_nxt = rdata_r;
        if (!unlit) begin
          alu_op = OP_MUL;
          alu_a  = NW'(LEVEL_MAX - rdata_r);
          alu_b  = NW'(r2_r - len_r[R2W-1:0]);
        end
      end
      ST_P_SCALE: begin
        n_nxt  = alu_res[NW-1:0];
        alu_op = OP_MUL;
        alu_a  = alu_res[NW-1:0];
        alu_b  = recip_r;
      end
      ST_P_CORR: begin
        qe_nxt = alu_res[NW +: 8];
        alu_op = OP_MUL;
        alu_a  = NW'(alu_res[NW +: 8]);
        alu_b  = NW'(r2_r);
      end
      ST_P_WR: begin
        mem_we    = 1'b1;
        mem_wdata = m_r + qe_r + 8'(bump);
      end
      ST_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_level_nxt  = (kind_r == REQ_READ) ? m_r : 8'd0;
          out_add_nxt    = (kind_r == REQ_ADD);
        end
      end
      default: begin
        alu_op = OP_HOLD;
      end
    endcase

    // step to the next pixel of the window
    if ((state_r == ST_P_WR) || ((state_r == ST_P_MIX) && unlit)) begin
      if (!x_last) begin
        x_nxt    = x_inc;
        dxsq_nxt = sq_step(dxsq_r, x_r - cx_r);
      end else begin
        x_nxt    = x0_r;
        dxsq_nxt = dx0sq_r;
        if (!y_last) begin
          y_nxt    = y_inc;
          dysq_nxt = sq_step(dysq_r, y_r - cy_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    in_map_r    <= in_map_nxt;
    cy_r        <= cy_nxt;
    cx_r        <= cx_nxt;
    r_r         <= r_nxt;
    y0_r        <= y0_nxt;
    y1_r        <= y1_nxt;
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    y_r         <= y_nxt;
    x_r         <= x_nxt;
    r2_r        <= r2_nxt;
    dysq_r      <= dysq_nxt;
    dxsq_r      <= dxsq_nxt;
    dx0sq_r     <= dx0sq_nxt;
    recip_r     <= recip_nxt;
    len_r       <= len_nxt;
    m_r         <= m_nxt;
    n_r         <= n_nxt;
    qe_r        <= qe_nxt;
    div_cnt_r   <= div_cnt_nxt;
    out_level_r <= out_level_nxt;
    out_add_r   <= out_add_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) light_map_r[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rdata_r <= light_map_r[mem_raddr];
  end

  assign in_tready    = (state_r == ST_IDLE);
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_level_r;
  assign out_tuser[0] = out_add_r;

  `RLMA_ASSERT_NOW(a_wr_in_window, state_r == ST_P_WR, in_win, "map write outside the window")
  `RLMA_ASSERT_NOW(a_recip_err, state_r == ST_P_WR, rem_w < r2_dbl, "quotient error above one")
  `RLMA_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "ready not dropped")

endmodule

/* dv/rlma_light_map_checker.sv */
// Checker for the radial light map accumulator: watches both stream channels,
// keeps its own copy of the light map and compares every result in order.
// Depends on rlma_pkg for field positions, widths and request kinds.
`timescale 1ns / 1ps

module rlma_light_map_checker
  import rlma_pkg::*;
#(
  parameter int TILE_PIXELS      = 16,
  parameter int MAP_HEIGHT_TILES = 16,
  parameter int MAP_WIDTH_TILES  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]             out_tuser,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int MAP_ROWS = MAP_HEIGHT_TILES * TILE_PIXELS;
  localparam int MAP_COLS = MAP_WIDTH_TILES * TILE_PIXELS;

  typedef struct packed {
    logic [7:0] level;
    logic       was_add;
  } light_result_t;

  light_result_t expected_results[$];
  logic [7:0]    light_map[MAP_ROWS * MAP_COLS];

  function automatic int clamp_to_span(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic add_light(int ty, int tx, int rt);
    int     cy, cx, r, y0, y1, x0, x1, dy, dx;
    longint r2, dist2, m;
    cy = ty * TILE_PIXELS + TILE_PIXELS / 2;
    cx = tx * TILE_PIXELS + TILE_PIXELS / 2;
    r  = rt * TILE_PIXELS;
    r2 = longint'(r) * r;
    if (r2 == 0) return;
    y0 = clamp_to_span(cy - r, MAP_ROWS);
    y1 = clamp_to_span(cy + r, MAP_ROWS);
    x0 = clamp_to_span(cx - r, MAP_COLS);
    x1 = clamp_to_span(cx + r, MAP_COLS);
    for (int y = y0; y < y1; y++) begin
      dy = (y < cy) ? cy - y : y - cy;
      for (int x = x0; x < x1; x++) begin
        dx = (x < cx) ? cx - x : x - cx;
        dist2 = longint'(dx) * dx + longint'(dy) * dy;
        if (dist2 <= r2) begin
          m = longint'(light_map[y * MAP_COLS + x]);
          m = m + ((255 - m) * (r2 - dist2)) / r2;
          light_map[y * MAP_COLS + x] = (m > 255) ? LEVEL_MAX : 8'(m);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    light_result_t want;
    int            py, px;
    if (!rst_n) begin
      mismatches  = 0;
      outstanding = 0;
      expected_results.delete();
      foreach (light_map[i]) light_map[i] = '0;
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: light_level=%0d was_add=%0d", out_tdata, out_tuser[0]);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata !== want.level) begin
            $error("light_level: expected %0d, got %0d", want.level, out_tdata);
            mismatches++;
          end
          if (out_tuser[0] !== want.was_add) begin
            $error("was_add: expected %0d, got %0d", want.was_add, out_tuser[0]);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == REQ_ADD) begin
          add_light(int'(in_tdata[TY_LSB +: 4]), int'(in_tdata[TX_LSB +: 4]),
                    int'(in_tdata[RT_LSB +: 4]));
          want.level   = '0;
          want.was_add = 1'b1;
        end else begin
          py = int'(in_tdata[PY_LSB +: 8]);
          px = int'(in_tdata[PX_LSB +: 8]);
          want.level   = (py < MAP_ROWS && px < MAP_COLS) ? light_map[py * MAP_COLS + px] : '0;
          want.was_add = 1'b0;
        end
        expected_results = {expected_results, want};
      end
      outstanding = expected_results.size();
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top for the radial light map accumulator: clock, reset, request
// stimulus with bursts and gaps, result back-pressure and the verdict.
// Depends on rlma_pkg, radial_light_map_accumulator_top and rlma_light_map_checker.
`timescale 1ns / 1ps

module tb;
  import rlma_pkg::*;

  localparam int IDLE_LIMIT = 2_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  int mismatches, outstanding;
  int burst_left = 0;
  int idle_cycles = 0;
  int last_cy = 8, last_cx = 8, last_span = 16;
  bit squeeze_rx = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  radial_light_map_accumulator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rlma_light_map_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic int to_pixel(int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // one request; returns at the edge that took it
  task automatic put_request(logic kind, int ty, int tx, int rt, int py, int px);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[TY_LSB +: 4] = 4'(ty);
    d[TX_LSB +: 4] = 4'(tx);
    d[RT_LSB +: 4] = 4'(rt);
    d[PY_LSB +: 8] = 8'(py);
    d[PX_LSB +: 8] = 8'(px);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 6);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_ADD) begin
      last_cy   = ty * 16 + 8;
      last_cx   = tx * 16 + 8;
      last_span = (rt == 0) ? 16 : rt * 16;
    end
  endtask

  task automatic add_source(int ty, int tx, int rt);
    put_request(REQ_ADD, ty, tx, rt, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic read_pixel(int py, int px);
    put_request(REQ_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 15), py, px);
  endtask

  task automatic read_near_light();
    read_pixel(to_pixel(last_cy + int'($urandom_range(0, 2 * last_span)) - last_span),
               to_pixel(last_cx + int'($urandom_range(0, 2 * last_span)) - last_span));
  endtask

  // stimulus
  initial begin
    int sel;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_ADD;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    read_pixel(0, 0);
    read_pixel(255, 255);
    add_source(0, 0, 0);
    read_pixel(8, 8);
    add_source(0, 0, 1);
    read_pixel(0, 0);
    read_pixel(8, 8);
    read_pixel(8, 24);
    read_pixel(23, 8);
    add_source(15, 15, 2);
    read_pixel(248, 248);
    read_pixel(255, 255);
    add_source(7, 9, 1);
    add_source(7, 9, 1);
    read_pixel(120, 152);
    read_pixel(125, 150);
    add_source(15, 0, 15);
    read_pixel(0, 255);
    read_pixel(255, 0);
    read_pixel(128, 128);
    add_source(0, 15, 4);
    read_pixel(8, 248);
    read_pixel(60, 200);

    // results are held back for a while here; reads are offered without gaps meanwhile
    squeeze_rx = 1'b1;
    burst_left = 12;
    repeat (10) read_near_light();

    for (int i = 0; i < 90; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        sel = $urandom_range(0, 9);
        add_source($urandom_range(0, 15), $urandom_range(0, 15),
                   (sel < 2) ? 0 : (sel < 6) ? 1 : (sel < 9) ? 2 : 3);
      end else if ($urandom_range(0, 9) < 7) begin
        read_near_light();
      end else begin
        read_pixel($urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int mode, mode_left;
    bit squeezed;
    mode_left = 0;
    mode      = 0;
    squeezed  = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (squeeze_rx && !squeezed) begin
        squeezed = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 400);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // no handshake on either channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule

/* radial_light_map_accumulator_top.f */
+incdir+rtl
rtl/rlma_pkg.sv
rtl/rlma_alu.sv
rtl/radial_light_map_accumulator_top.sv
dv/rlma_light_map_checker.sv
dv/tb.sv
